/* sv/raster_row_runs_to_rectangles_assert.svh */
// Assertion macros for the raster row run vectorizer checker.
// Needs nothing else; included by the checker file.
`ifndef RASTER_ROW_RUNS_TO_RECTANGLES_ASSERT_SVH
`define RASTER_ROW_RUNS_TO_RECTANGLES_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define RRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/rrr_pkg.sv */
// Shared constants, types and helpers of the raster row run vectorizer.
// No dependencies; imported by every module of the block.
package rrr_pkg;

	// image size limit and derived widths
	localparam int MAX_DIM = 1024;
	localparam int DIM_W   = $clog2(MAX_DIM);      // column / row index
	localparam int EXT_W   = $clog2(MAX_DIM + 1);  // index that may equal the size

	// output frame
	localparam int FRAME_SPAN  = 9000;
	localparam int FRAME_LEFT  = 1000;
	localparam int FRAME_TOP   = 9500;
	localparam int ALPHA_LIMIT = 127;
	localparam int COORD_W     = 14;
	localparam int COLOR_W     = 24;

	// divider sizing: quotient never exceeds FRAME_SPAN
	localparam int QUO_W  = $clog2(FRAME_SPAN + 1);
	localparam int PROD_W = $clog2(MAX_DIM * FRAME_SPAN + 1);
	localparam int SHF_W  = EXT_W + QUO_W - 1;
	localparam int DIV_W  = (SHF_W > PROD_W) ? SHF_W : PROD_W;
	localparam int STEP_W = $clog2(QUO_W);

	// configuration port
	localparam int REG_W     = 11;
	localparam int CHAN_W    = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANS  = 2'd2;

	// channel count codes; anything else is read as RGBA
	localparam logic [CHAN_W-1:0] CH_GRAY       = 3'd1;
	localparam logic [CHAN_W-1:0] CH_GRAY_ALPHA = 3'd2;
	localparam logic [CHAN_W-1:0] CH_RGB        = 3'd3;

	// coordinate operations of one rectangle, in order
	localparam logic [1:0] OP_X0 = 2'd0;
	localparam logic [1:0] OP_X1 = 2'd1;
	localparam logic [1:0] OP_Y0 = 2'd2;
	localparam logic [1:0] OP_Y1 = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_OUT
	} seq_state_t;

	// decoded pixel
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               opaque;
	} pix_t;

	// size register as used: zero reads as one, large values saturate
	function automatic logic [EXT_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
		logic [EXT_W-1:0] r;
		if (v == '0) begin
			r = EXT_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = EXT_W'(MAX_DIM);
		end else begin
			r = EXT_W'(v);
		end
		return r;
	endfunction

endpackage

/* sv/rrr_pix.sv */
// Pixel decoder: channel bytes to packed color and opacity.
// Depends on rrr_pkg.
module rrr_pix (
	input  logic [7:0]                 chan0,
	input  logic [7:0]                 chan1,
	input  logic [7:0]                 chan2,
	input  logic [7:0]                 chan3,
	input  logic [rrr_pkg::CHAN_W-1:0] chans,
	output rrr_pkg::pix_t              pix
);
	import rrr_pkg::*;

	logic [COLOR_W-1:0] color;
	logic               opaque;

	// pick layout by channel count
	always_comb begin
		unique case (chans)
			CH_GRAY: begin
				color  = {chan0, chan0, chan0};
				opaque = 1'b1;
			end
			CH_GRAY_ALPHA: begin
				color  = {chan0, chan0, chan0};
				opaque = chan1 > 8'(ALPHA_LIMIT);
			end
			CH_RGB: begin
				color  = {chan0, chan1, chan2};
				opaque = 1'b1;
			end
			default: begin
				color  = {chan0, chan1, chan2};
				opaque = chan3 > 8'(ALPHA_LIMIT);
			end
		endcase
	end

	// all transparent pixels share one color
	assign pix.color  = opaque ? color : '0;
	assign pix.opaque = opaque;

endmodule

/* sv/rrr_div.sv */
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on rrr_pkg. Dividend must be below divisor * 2**QUO_W.
module rrr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rrr_pkg::PROD_W-1:0] dividend,
	input  logic [rrr_pkg::EXT_W-1:0]  divisor,
	output logic                       done,
	output logic [rrr_pkg::QUO_W-1:0]  quotient
);
	import rrr_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [EXT_W-1:0]  dsr_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W-1:0]  shifted;
	logic              fits;

	// trial subtract of the divisor aligned to the current bit
	assign shifted = DIV_W'(dsr_q) << step_q;
	assign fits    = rem_q >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_W'(dividend);
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - shifted;
			end
			quo_q[step_q] <= fits;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* sv/raster_row_runs_to_rectangles.sv */
// Raster row run vectorizer: pixels in, one rectangle item per closed opaque run out.
// Depends on rrr_pkg, rrr_pix and rrr_div.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_stall  chan0..chan3
//   out      out        out_valid/out_stall  red..bottom_y, last
//
// A pixel that closes no run is taken without a stall. Each rectangle is computed as four
// coordinates, each of one multiply, one divider start, one divide step per quotient bit and
// a quotient write, then one output load; a pixel closes up to two. in_stall is high from the
// cycle after the accept until the last rectangle is loaded, longer while the output register is stalled.
// Reset clears the frame position and the size registers go to 16 x 16, RGB.
module raster_row_runs_to_rectangles (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrr_pkg::REG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    chan0,
	input  logic [7:0]                    chan1,
	input  logic [7:0]                    chan2,
	input  logic [7:0]                    chan3,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [rrr_pkg::COORD_W-1:0]   left_x,
	output logic [rrr_pkg::COORD_W-1:0]   right_x,
	output logic [rrr_pkg::COORD_W-1:0]   top_y,
	output logic [rrr_pkg::COORD_W-1:0]   bottom_y,
	output logic                          last
);
	import rrr_pkg::*;

	// configuration
	logic [REG_W-1:0]  width_q;
	logic [REG_W-1:0]  height_q;
	logic [CHAN_W-1:0] chans_q;
	logic [EXT_W-1:0]  w_eff;
	logic [EXT_W-1:0]  h_eff;
	logic              cfg_hit;

	// run state
	logic [DIM_W-1:0]   col_q;
	logic [DIM_W-1:0]   row_q;
	logic [DIM_W-1:0]   start_q;
	logic [COLOR_W-1:0] color_q;
	logic               opaque_q;

	// per-pixel decisions
	pix_t               pix;
	logic               in_acc;
	logic               restart;
	logic [DIM_W-1:0]   c_col;
	logic [DIM_W-1:0]   c_row;
	logic [DIM_W-1:0]   c_start;
	logic               c_op;
	logic               change;
	logic               emit_a;
	logic               emit_b;
	logic               eol;
	logic [DIM_W-1:0]   n_start;
	logic [COLOR_W-1:0] n_color;
	logic               n_op;
	logic [EXT_W-1:0]   row_next;

	// pending rectangles
	logic [1:0]         jv_q;
	logic [COLOR_W-1:0] jcol_q [2];
	logic [DIM_W-1:0]   jx0_q [2];
	logic [EXT_W-1:0]   jx1_q [2];
	logic [DIM_W-1:0]   jy_q;
	logic               cur_q;
	logic               more;

	// sequencer and shared divider
	seq_state_t         st_q;
	seq_state_t         st_d;
	logic [1:0]         op_q;
	logic               div_start;
	logic               div_done;
	logic               q_we;
	logic               out_load;
	logic [EXT_W-1:0]   operand;
	logic [EXT_W-1:0]   divisor;
	logic [PROD_W-1:0]  prod_q;
	logic [QUO_W-1:0]   quotient;
	logic [QUO_W-1:0]   qv_q [4];
	logic               out_valid_q;

	assign w_eff   = clamp_dim(width_q);
	assign h_eff   = clamp_dim(height_q);
	assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_CHANS);

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	rrr_pix u_pix (
		.chan0 (chan0),
		.chan1 (chan1),
		.chan2 (chan2),
		.chan3 (chan3),
		.chans (chans_q),
		.pix   (pix)
	);

	// run tracking for the incoming pixel
	always_comb begin
		restart = (EXT_W'(col_q) >= w_eff) || (EXT_W'(row_q) >= h_eff);
		c_col   = restart ? '0 : col_q;
		c_row   = restart ? '0 : row_q;
		c_start = (restart || c_col == '0) ? '0 : start_q;
		c_op    = (restart || c_col == '0) ? 1'b0 : opaque_q;
		change  = (pix.opaque != c_op) || (pix.opaque && pix.color != color_q);
		emit_a  = change && (c_col > c_start) && c_op;
		n_op    = change ? pix.opaque : c_op;
		n_color = change ? pix.color : color_q;
		n_start = change ? c_col : c_start;
		eol     = (EXT_W'(c_col) + EXT_W'(1)) >= w_eff;
		emit_b  = eol && n_op;
		row_next = EXT_W'(c_row) + EXT_W'(1);
	end

	// configuration registers and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= REG_W'(16);
			height_q <= REG_W'(16);
			chans_q  <= CHAN_W'(3);
			col_q    <= '0;
			row_q    <= '0;
			start_q  <= '0;
			color_q  <= '0;
			opaque_q <= 1'b0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    chans_q  <= cfg_data[CHAN_W-1:0];
			endcase
			col_q    <= '0;
			row_q    <= '0;
			start_q  <= '0;
			opaque_q <= 1'b0;
		end else if (in_acc) begin
			color_q <= n_color;
			if (eol) begin
				col_q    <= '0;
				start_q  <= '0;
				opaque_q <= 1'b0;
				row_q    <= (row_next >= h_eff) ? '0 : row_next[DIM_W-1:0];
			end else begin
				col_q    <= c_col + 1'b1;
				start_q  <= n_start;
				opaque_q <= n_op;
				row_q    <= c_row;
			end
		end
	end

	// capture the rectangles this pixel closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q <= '0;
		end else if (in_acc) begin
			jv_q <= {emit_b, emit_a};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			jcol_q[0] <= color_q;
			jx0_q[0]  <= c_start;
			jx1_q[0]  <= EXT_W'(c_col);
			jcol_q[1] <= n_color;
			jx0_q[1]  <= n_start;
			jx1_q[1]  <= w_eff;
			jy_q      <= c_row;
		end
	end

	assign more = !cur_q && jv_q[1];

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sequencer next state and strobes
	always_comb begin
		st_d      = st_q;
		div_start = 1'b0;
		q_we      = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc && (emit_a || emit_b)) begin
					st_d = ST_MUL;
				end
			end
			ST_MUL: begin
				st_d = ST_DSTART;
			end
			ST_DSTART: begin
				div_start = 1'b1;
				st_d      = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (div_done) begin
					q_we = 1'b1;
					st_d = (op_q == OP_Y1) ? ST_OUT : ST_MUL;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_d     = more ? ST_MUL : ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// coordinate step and rectangle index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= OP_X0;
			cur_q <= 1'b0;
		end else begin
			if (q_we) begin
				op_q <= op_q + 2'd1;
			end
			if (in_acc && (emit_a || emit_b)) begin
				cur_q <= !emit_a;
			end else if (out_load && more) begin
				cur_q <= 1'b1;
			end
		end
	end

	// operand and divisor for the current coordinate
	always_comb begin
		case (op_q)
			OP_X0:   operand = EXT_W'(jx0_q[cur_q]);
			OP_X1:   operand = jx1_q[cur_q];
			OP_Y0:   operand = EXT_W'(jy_q);
			default: operand = EXT_W'(jy_q) + EXT_W'(1);
		endcase
		divisor = (op_q == OP_Y0 || op_q == OP_Y1) ? h_eff : w_eff;
	end

	// scale by the frame span, then divide by the image size
	always_ff @(posedge clk) begin
		if (st_q == ST_MUL) begin
			prod_q <= PROD_W'(operand) * PROD_W'(FRAME_SPAN);
		end
		if (q_we) begin
			qv_q[op_q] <= quotient;
		end
	end

	rrr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red      <= jcol_q[cur_q][23:16];
			green    <= jcol_q[cur_q][15:8];
			blue     <= jcol_q[cur_q][7:0];
			left_x   <= COORD_W'(qv_q[OP_X0]) + COORD_W'(FRAME_LEFT);
			right_x  <= COORD_W'(qv_q[OP_X1]) + COORD_W'(FRAME_LEFT);
			top_y    <= COORD_W'(FRAME_TOP) - COORD_W'(qv_q[OP_Y0]);
			bottom_y <= COORD_W'(FRAME_TOP) - COORD_W'(qv_q[OP_Y1]);
			last     <= !more;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/rrr_checker.sv */
// Port-level checks of the raster row run vectorizer, bound to the top level.
// Depends on rrr_pkg and raster_row_runs_to_rectangles_assert.svh.
`include "raster_row_runs_to_rectangles_assert.svh"

module rrr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rrr_pkg::COORD_W-1:0]   left_x,
	input logic [rrr_pkg::COORD_W-1:0]   right_x,
	input logic [rrr_pkg::COORD_W-1:0]   top_y,
	input logic [rrr_pkg::COORD_W-1:0]   bottom_y,
	input logic                          last
);
	import rrr_pkg::*;

	// a stalled item stays offered
	`RRR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "out item dropped while stalled")

	// a stalled item keeps its coordinates
	`RRR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(left_x) && $stable(right_x) && $stable(top_y) && $stable(bottom_y) && $stable(last), "out item changed while stalled")

	// rectangles lie inside the frame's left and top edges and are not inverted
	`RRR_ASSERT_NOW(a_rect_shape, clk, arst_n, out_valid, left_x <= right_x && bottom_y <= top_y && left_x >= COORD_W'(FRAME_LEFT) && top_y <= COORD_W'(FRAME_TOP), "rectangle out of frame or inverted")

	// a new rectangle only appears out of a busy period
	`RRR_ASSERT_NOW(a_out_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "rectangle without a pixel being processed")

endmodule

bind raster_row_runs_to_rectangles rrr_checker u_rrr_checker (.*);
